// ----- rtl/core/sfd_pkg.sv -----
// Shared constants and codes for the S.BUS frame decoder.
// No dependencies; every other file imports this package.
`default_nettype none

package sfd_pkg;

	localparam int unsigned BYTE_W      = 8;
	localparam int unsigned CHAN_W      = 11;
	localparam int unsigned CHAN_IDX_W  = 4;
	localparam int unsigned LINK_W      = 2;
	localparam int unsigned STORE_DEPTH = 24;
	localparam int unsigned ADDR_W      = $clog2(STORE_DEPTH + 1);

	localparam logic [BYTE_W-1:0] FRAME_HEADER = 8'h0f;
	localparam logic [BYTE_W-1:0] FRAME_END    = 8'h00;

	localparam logic [ADDR_W-1:0] HEADER_ADDR     = ADDR_W'(0);
	localparam logic [ADDR_W-1:0] FIRST_DATA_ADDR = ADDR_W'(1);
	localparam logic [ADDR_W-1:0] STATUS_ADDR     = ADDR_W'(STORE_DEPTH - 1);
	localparam logic [ADDR_W-1:0] STORE_FULL      = ADDR_W'(STORE_DEPTH);

	// Status byte bits.
	localparam int unsigned DIG_ONE_BIT  = 0;
	localparam int unsigned DIG_TWO_BIT  = 1;
	localparam int unsigned LOST_BIT     = 2;
	localparam int unsigned FAILSAFE_BIT = 3;

	// Item kinds.
	localparam logic KIND_BYTE = 1'b0;
	localparam logic KIND_GAP  = 1'b1;

	// Link status codes.
	localparam logic [LINK_W-1:0] LINK_OK       = 2'd0;
	localparam logic [LINK_W-1:0] LINK_LOST     = 2'd1;
	localparam logic [LINK_W-1:0] LINK_FAILSAFE = 2'd2;

	localparam logic [CHAN_IDX_W-1:0] LAST_CHAN_ALL  = 4'd15;
	localparam logic [CHAN_IDX_W-1:0] LAST_CHAN_HALF = 4'd7;

endpackage

`default_nettype wire

// ----- rtl/core/sfd_ifs.sv -----
// Valid/ready channel interfaces for the S.BUS frame decoder:
// the received-byte input channel and the decoded-channel output channel.
// Depends on sfd_pkg.
`default_nettype none

interface sfd_rx_if;
	import sfd_pkg::*;

	logic              valid;
	logic              ready;
	logic              kind;
	logic [BYTE_W-1:0] rx_byte;

	modport source (output valid, output kind, output rx_byte, input ready);
	modport sink   (input valid, input kind, input rx_byte, output ready);
endinterface

interface sfd_chan_if;
	import sfd_pkg::*;

	logic                  valid;
	logic                  ready;
	logic [CHAN_IDX_W-1:0] channel_index;
	logic [CHAN_W-1:0]     channel_value;
	logic                  digital_one;
	logic                  digital_two;
	logic [LINK_W-1:0]     link_status;
	logic                  last_channel;

	modport source (output valid, output channel_index, output channel_value,
		output digital_one, output digital_two, output link_status,
		output last_channel, input ready);
	modport sink   (input valid, input channel_index, input channel_value,
		input digital_one, input digital_two, input link_status,
		input last_channel, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/sbus_frame_decoder.sv -----
// S.BUS frame decoder: input transfers are accepted only while no frame is decoding.
// After a good end byte the block reads the status byte, then streams data bytes
// out of the frame store (one write port, one read port) and emits one channel at a time,
// eight channels or sixteen, input held off meanwhile. Reset clears control
// state and selects sixteen channels; the frame store contents stay undefined.
`default_nettype none

module sbus_frame_decoder (
	input  wire        clk,
	input  wire        arst_n,
	sfd_rx_if.sink     rx,
	sfd_chan_if.source chan,
	input  wire        cfg_we,
	input  wire        cfg_wdata
);
	import sfd_pkg::*;

	localparam int unsigned ST_W = 3;
	localparam logic [ST_W-1:0] ST_IDLE  = 3'd0;
	localparam logic [ST_W-1:0] ST_STAT  = 3'd1;
	localparam logic [ST_W-1:0] ST_STATW = 3'd2;
	localparam logic [ST_W-1:0] ST_FILL  = 3'd3;
	localparam logic [ST_W-1:0] ST_WAIT  = 3'd4;

	localparam int unsigned BUF_W  = CHAN_W + BYTE_W - 1;
	localparam int unsigned NBIT_W = $clog2(BUF_W + 1);

	logic [ST_W-1:0]       state_q;
	logic                  all_chan_q;
	logic                  in_frame_q;
	logic [ADDR_W-1:0]     pos_q;
	logic [ADDR_W-1:0]     rd_ptr_q;
	logic [BUF_W-1:0]      bits_q;
	logic [NBIT_W-1:0]     nbits_q;
	logic [CHAN_IDX_W-1:0] chan_q;
	logic                  dig_one_q;
	logic                  dig_two_q;
	logic [LINK_W-1:0]     link_q;

	logic                  out_valid_q;
	logic [CHAN_IDX_W-1:0] out_index_q;
	logic [CHAN_W-1:0]     out_value_q;
	logic                  out_dig_one_q;
	logic                  out_dig_two_q;
	logic [LINK_W-1:0]     out_link_q;
	logic                  out_last_q;

	// Frame store: one write port for incoming bytes, one registered read port.
	logic [BYTE_W-1:0] store_mem [STORE_DEPTH];
	logic              mem_we;
	logic [ADDR_W-1:0] mem_waddr;
	logic              mem_re;
	logic [ADDR_W-1:0] mem_raddr;
	logic [BYTE_W-1:0] mem_rdata;

	logic rx_xfer;
	logic out_free;
	logic have_chan;
	logic emit;
	logic [CHAN_IDX_W-1:0] last_chan;

	assign rx.ready  = (state_q == ST_IDLE);
	assign rx_xfer   = rx.valid && rx.ready;
	assign out_free  = !out_valid_q || chan.ready;
	assign have_chan = (nbits_q >= NBIT_W'(CHAN_W));
	assign emit      = (state_q == ST_FILL) && have_chan && out_free;
	assign last_chan = all_chan_q ? LAST_CHAN_ALL : LAST_CHAN_HALF;

	// Writes happen only while idle and reads only while decoding, so the
	// two ports never touch the same entry in one cycle.
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = pos_q;
		if (rx_xfer && rx.kind == KIND_BYTE) begin
			if (!in_frame_q) begin
				mem_we    = (rx.rx_byte == FRAME_HEADER);
				mem_waddr = HEADER_ADDR;
			end else if (pos_q < STORE_FULL) begin
				mem_we = 1'b1;
			end
		end
	end

	always_comb begin
		mem_re    = 1'b0;
		mem_raddr = rd_ptr_q;
		unique case (state_q)
			ST_STAT: begin
				mem_re    = 1'b1;
				mem_raddr = STATUS_ADDR;
			end
			ST_FILL: begin
				mem_re = !have_chan;
			end
			ST_IDLE, ST_STATW, ST_WAIT: begin
				mem_re = 1'b0;
			end
			default: begin
				mem_re = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			store_mem[mem_waddr] <= rx.rx_byte;
		end
		if (mem_re) begin
			mem_rdata <= store_mem[mem_raddr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			all_chan_q <= 1'b1;
		end else if (cfg_we) begin
			all_chan_q <= cfg_wdata;
		end
	end

	// Framing and decode sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			in_frame_q  <= 1'b0;
			pos_q       <= '0;
			rd_ptr_q    <= FIRST_DATA_ADDR;
			nbits_q     <= '0;
			chan_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (chan.ready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (rx_xfer) begin
						if (rx.kind == KIND_GAP) begin
							in_frame_q <= 1'b0;
							pos_q      <= '0;
						end else if (!in_frame_q) begin
							if (rx.rx_byte == FRAME_HEADER) begin
								in_frame_q <= 1'b1;
								pos_q      <= FIRST_DATA_ADDR;
							end
						end else if (pos_q < STORE_FULL) begin
							pos_q <= pos_q + ADDR_W'(1);
						end else begin
							in_frame_q <= 1'b0;
							pos_q      <= '0;
							if (rx.rx_byte == FRAME_END) begin
								state_q <= ST_STAT;
							end
						end
					end
				end
				ST_STAT: begin
					state_q <= ST_STATW;
				end
				ST_STATW: begin
					rd_ptr_q <= FIRST_DATA_ADDR;
					nbits_q  <= '0;
					chan_q   <= '0;
					state_q  <= ST_FILL;
				end
				ST_FILL: begin
					if (!have_chan) begin
						rd_ptr_q <= rd_ptr_q + ADDR_W'(1);
						state_q  <= ST_WAIT;
					end else if (out_free) begin
						nbits_q     <= nbits_q - NBIT_W'(CHAN_W);
						chan_q      <= chan_q + CHAN_IDX_W'(1);
						if (chan_q == last_chan) begin
							state_q <= ST_IDLE;
						end
					end
				end
				ST_WAIT: begin
					nbits_q <= nbits_q + NBIT_W'(BYTE_W);
					state_q <= ST_FILL;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Payload registers: the bit window, status fields and output result.
	always_ff @(posedge clk) begin
		if (state_q == ST_STATW) begin
			bits_q    <= '0;
			dig_one_q <= mem_rdata[DIG_ONE_BIT];
			dig_two_q <= mem_rdata[DIG_TWO_BIT];
			if (mem_rdata[FAILSAFE_BIT]) begin
				link_q <= LINK_FAILSAFE;
			end else if (mem_rdata[LOST_BIT]) begin
				link_q <= LINK_LOST;
			end else begin
				link_q <= LINK_OK;
			end
		end else if (state_q == ST_WAIT) begin
			// New byte lands just above the bits still held; upper bits are zero.
			bits_q <= bits_q | (BUF_W'(mem_rdata) << nbits_q);
		end else if (emit) begin
			bits_q        <= bits_q >> CHAN_W;
			out_index_q   <= chan_q;
			out_value_q   <= bits_q[CHAN_W-1:0];
			out_dig_one_q <= dig_one_q;
			out_dig_two_q <= dig_two_q;
			out_link_q    <= link_q;
			out_last_q    <= (chan_q == last_chan);
		end
	end

	assign chan.valid         = out_valid_q;
	assign chan.channel_index = out_index_q;
	assign chan.channel_value = out_value_q;
	assign chan.digital_one   = out_dig_one_q;
	assign chan.digital_two   = out_dig_two_q;
	assign chan.link_status   = out_link_q;
	assign chan.last_channel  = out_last_q;

endmodule

`default_nettype wire

// ----- rtl/core/sfd_checker.sv -----
// Port-level checks for the S.BUS frame decoder and the bind that attaches them.
// Depends on sfd_pkg and on the ports of sbus_frame_decoder.
`default_nettype none

module sfd_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        rx_ready,
	input wire        chan_valid,
	input wire        chan_ready,
	input wire [3:0]  chan_index,
	input wire [1:0]  chan_link,
	input wire        chan_last
);
	import sfd_pkg::*;

	// A stalled result keeps its channel number.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		chan_valid && !chan_ready |=> chan_valid && $stable(chan_index))
		else $error("result changed while stalled");

	// Input stays closed while a frame still has channels to deliver.
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		chan_valid && !chan_last |-> !rx_ready)
		else $error("input open in the middle of a frame");

	// Final result of a frame is channel seven or channel fifteen.
	a_last: assert property (@(posedge clk) disable iff (!arst_n)
		chan_valid && chan_last |->
			chan_index == LAST_CHAN_HALF || chan_index == LAST_CHAN_ALL)
		else $error("last flag on an unexpected channel");

	// Only three link codes exist.
	a_link: assert property (@(posedge clk) disable iff (!arst_n)
		chan_valid |-> chan_link == LINK_OK || chan_link == LINK_LOST ||
			chan_link == LINK_FAILSAFE)
		else $error("invalid link status");

endmodule

bind sbus_frame_decoder sfd_checker u_sfd_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.rx_ready   (rx.ready),
	.chan_valid (chan.valid),
	.chan_ready (chan.ready),
	.chan_index (chan.channel_index),
	.chan_link  (chan.link_status),
	.chan_last  (chan.last_channel)
);

`default_nettype wire

// ----- tb/sfd_frame_checker.sv -----
// Scoreboard for the S.BUS frame decoder: watches the byte and channel channels,
// predicts every decoded channel transfer and compares it field by field.
// Depends on sfd_pkg and the channel interfaces in sfd_ifs.
`default_nettype none

module sfd_frame_checker
	import sfd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	sfd_rx_if           rx,
	sfd_chan_if         chan,
	input  logic        cfg_we,
	input  logic        cfg_wdata,
	output int unsigned fail_count,
	output int unsigned outstanding
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic [CHAN_IDX_W-1:0] idx;
		logic [CHAN_W-1:0]     value;
		logic                  dig_one;
		logic                  dig_two;
		logic [LINK_W-1:0]     link;
		logic                  last;
	} channel_result_t;

	logic              sixteen_mode;
	logic              in_frame;
	logic [ADDR_W-1:0] fill_level;
	logic [BYTE_W-1:0] frame_bytes [STORE_DEPTH];
	channel_result_t   expected_channels [$];

	initial fail_count = 0;

	// Channels are packed LSB first from the first data byte; a channel spans
	// at most three bytes.
	function automatic logic [CHAN_W-1:0] unpack_channel(int unsigned c);
		int unsigned bitpos;
		int unsigned b;
		logic [23:0] w;
		bitpos = CHAN_W * c;
		b = FIRST_DATA_ADDR + bitpos / 8;
		w = {frame_bytes[b + 2], frame_bytes[b + 1], frame_bytes[b]};
		return CHAN_W'(w >> (bitpos % 8));
	endfunction

	task automatic take_rx_item(input logic kind, input logic [BYTE_W-1:0] data);
		logic [BYTE_W-1:0]     status;
		logic [LINK_W-1:0]     link;
		logic [CHAN_IDX_W-1:0] last_idx;
		channel_result_t       r;
		if (kind == KIND_GAP) begin
			in_frame = 1'b0;
			fill_level = '0;
		end else if (!in_frame) begin
			if (data == FRAME_HEADER) begin
				frame_bytes[HEADER_ADDR] = data;
				fill_level = FIRST_DATA_ADDR;
				in_frame = 1'b1;
			end
		end else if (fill_level < STORE_FULL) begin
			frame_bytes[fill_level] = data;
			fill_level = fill_level + ADDR_W'(1);
		end else begin
			in_frame = 1'b0;
			fill_level = '0;
			if (data == FRAME_END) begin
				status = frame_bytes[STATUS_ADDR];
				if (status[FAILSAFE_BIT])
					link = LINK_FAILSAFE;
				else if (status[LOST_BIT])
					link = LINK_LOST;
				else
					link = LINK_OK;
				last_idx = sixteen_mode ? LAST_CHAN_ALL : LAST_CHAN_HALF;
				for (int c = 0; c <= int'(last_idx); c++) begin
					r.idx     = CHAN_IDX_W'(c);
					r.value   = unpack_channel(c);
					r.dig_one = status[DIG_ONE_BIT];
					r.dig_two = status[DIG_TWO_BIT];
					r.link    = link;
					r.last    = (c == int'(last_idx));
					expected_channels.push_back(r);
				end
			end
		end
	endtask

	task automatic check_field(input string name, input logic [15:0] exp_v,
		input logic [15:0] act_v);
		if (act_v !== exp_v) begin
			$error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
			fail_count++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		channel_result_t e;
		if (!arst_n) begin
			sixteen_mode = 1'b1;
			in_frame = 1'b0;
			fill_level = '0;
			expected_channels.delete();
			outstanding <= 0;
		end else begin
			if (cfg_we)
				sixteen_mode = cfg_wdata;
			if (chan.valid && chan.ready) begin
				if (expected_channels.size() == 0) begin
					$error("channel transfer with nothing expected: index %0d value %0d",
						chan.channel_index, chan.channel_value);
					fail_count++;
				end else begin
					e = expected_channels.pop_front();
					check_field("channel_index", 16'(e.idx), 16'(chan.channel_index));
					check_field("channel_value", 16'(e.value), 16'(chan.channel_value));
					check_field("digital_one", 16'(e.dig_one), 16'(chan.digital_one));
					check_field("digital_two", 16'(e.dig_two), 16'(chan.digital_two));
					check_field("link_status", 16'(e.link), 16'(chan.link_status));
					check_field("last_channel", 16'(e.last), 16'(chan.last_channel));
				end
			end
			if (rx.valid && rx.ready)
				take_rx_item(rx.kind, rx.rx_byte);
			outstanding <= expected_channels.size();
		end
	end

endmodule

`default_nettype wire

// ----- tb/tb.sv -----
// Top of the S.BUS frame decoder testbench: clock, reset, byte stimulus, output
// back-pressure, register writes and the verdict. Depends on sfd_pkg, sfd_ifs,
// sbus_frame_decoder and sfd_frame_checker.
`default_nettype none

module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import sfd_pkg::*;

	localparam int unsigned IDLE_LIMIT    = 2000;
	localparam int unsigned SETTLE_CYCLES = 80;
	localparam int unsigned PHASE_ITEMS   = 12;
	localparam int unsigned DATA_BYTES    = STORE_DEPTH - 2;

	typedef enum {FILL_RANDOM, FILL_ZERO, FILL_ONES, FILL_HEADER} fill_t;

	logic        clk = 1'b0;
	logic        arst_n;
	logic        cfg_we;
	logic        cfg_wdata;
	logic        bursts_on;
	int unsigned fail_count;
	int unsigned outstanding;
	int unsigned items_sent;
	int unsigned quiet_cycles;

	sfd_rx_if   rx_bus ();
	sfd_chan_if chan_bus ();

	sbus_frame_decoder dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.rx        (rx_bus),
		.chan      (chan_bus),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	sfd_frame_checker scoreboard (
		.clk         (clk),
		.arst_n      (arst_n),
		.rx          (rx_bus),
		.chan        (chan_bus),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.fail_count  (fail_count),
		.outstanding (outstanding)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// The receiver stalls in random bursts while bursts are enabled.
	always begin
		@(posedge clk);
		if (bursts_on && $urandom_range(0, 5) == 0) begin
			chan_bus.ready <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		chan_bus.ready <= 1'b1;
	end

	always @(posedge clk) begin
		if ((rx_bus.valid && rx_bus.ready) || (chan_bus.valid && chan_bus.ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= IDLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// Leaves valid high after the transfer so back-to-back items need no toggle.
	task automatic send_item(input logic kind, input logic [BYTE_W-1:0] data);
		if (bursts_on && $urandom_range(0, 3) == 0) begin
			rx_bus.valid <= 1'b0;
			repeat ($urandom_range(1, 15)) @(posedge clk);
		end
		rx_bus.valid   <= 1'b1;
		rx_bus.kind    <= kind;
		rx_bus.rx_byte <= data;
		do @(posedge clk); while (!rx_bus.ready);
		items_sent++;
	endtask

	task automatic send_gap();
		send_item(KIND_GAP, BYTE_W'($urandom_range(0, 255)));
	endtask

	task automatic send_frame(input fill_t fill, input logic [BYTE_W-1:0] status,
		input logic [BYTE_W-1:0] end_byte);
		logic [BYTE_W-1:0] d;
		send_item(KIND_BYTE, FRAME_HEADER);
		for (int i = 0; i < DATA_BYTES; i++) begin
			case (fill)
				FILL_ZERO:   d = 8'h00;
				FILL_ONES:   d = 8'hff;
				FILL_HEADER: d = FRAME_HEADER;
				default:     d = BYTE_W'($urandom_range(0, 255));
			endcase
			send_item(KIND_BYTE, d);
		end
		send_item(KIND_BYTE, status);
		send_item(KIND_BYTE, end_byte);
	endtask

	// A frame cut short by a line gap after n stored bytes.
	task automatic send_aborted_frame(input int unsigned n);
		send_item(KIND_BYTE, FRAME_HEADER);
		repeat (n) send_item(KIND_BYTE, BYTE_W'($urandom_range(0, 255)));
		send_gap();
	endtask

	// Drops valid, waits for every decoded channel and lets the block go quiet.
	// The first edge lets the scoreboard count the transfer that just ended.
	task automatic settle();
		rx_bus.valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_channel_mode(input logic all);
		cfg_we    <= 1'b1;
		cfg_wdata <= all;
		@(posedge clk);
		cfg_we    <= 1'b0;
	endtask

	task automatic run_random_traffic(input int unsigned n_items);
		int unsigned stop_at;
		stop_at = items_sent + n_items;
		while (items_sent < stop_at) begin
			case ($urandom_range(0, 9))
				6: send_frame(FILL_RANDOM, BYTE_W'($urandom_range(0, 255)),
					BYTE_W'($urandom_range(1, 255)));
				7: send_aborted_frame($urandom_range(0, STORE_DEPTH - 1));
				8: begin
					repeat ($urandom_range(1, 4))
						send_item(KIND_BYTE, BYTE_W'($urandom_range(0, 255)));
					send_gap();
				end
				9: send_gap();
				default: send_frame(FILL_RANDOM, BYTE_W'($urandom_range(0, 255)), FRAME_END);
			endcase
		end
	endtask

	initial begin
		arst_n = 1'b0;
		rx_bus.valid   <= 1'b0;
		rx_bus.kind    <= KIND_BYTE;
		rx_bus.rx_byte <= '0;
		chan_bus.ready <= 1'b0;
		cfg_we         <= 1'b0;
		cfg_wdata      <= 1'b0;
		bursts_on      = 1'b1;
		items_sent     = 0;
		quiet_cycles   = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed frames at the reset setting of sixteen channels.
		send_gap();
		send_item(KIND_BYTE, 8'hff);
		send_item(KIND_BYTE, 8'h00);
		send_frame(FILL_ZERO, 8'h00, FRAME_END);
		send_frame(FILL_ONES, 8'h0f, FRAME_END);
		send_frame(FILL_HEADER, 8'h04, FRAME_END);
		send_frame(FILL_RANDOM, 8'hf3, FRAME_END);
		send_frame(FILL_RANDOM, 8'h08, FRAME_HEADER);
		send_aborted_frame(10);
		send_frame(FILL_RANDOM, 8'h02, FRAME_END);
		settle();

		set_channel_mode(1'b0);
		send_frame(FILL_ONES, 8'h01, FRAME_END);
		send_frame(FILL_RANDOM, 8'h0c, FRAME_END);
		run_random_traffic(PHASE_ITEMS);
		settle();

		set_channel_mode(1'b1);
		run_random_traffic(PHASE_ITEMS);
		settle();

		// Final stretch at full rate on both sides.
		bursts_on = 1'b0;
		set_channel_mode(1'b0);
		run_random_traffic(PHASE_ITEMS);
		settle();

		if (fail_count == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule

`default_nettype wire

// ----- filelist.f -----
rtl/core/sfd_pkg.sv
rtl/core/sfd_ifs.sv
rtl/core/sbus_frame_decoder.sv
rtl/core/sfd_checker.sv
tb/sfd_frame_checker.sv
tb/tb.sv
